// ===== rtl/mcsd_pkg.sv =====
// Package for the MIDI chord sequence detector.
// Holds the event and chord codes, the FSM state type, the controller/datapath
// command and status structs, and the helpers for pitch class and templates.
`timescale 1ns / 1ps

package mcsd_pkg;

  // Event kinds on the input channel.
  localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
  localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
  localparam logic [1:0] KIND_BUF_END  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_ENABLE  = 3'd0;
  localparam logic [2:0] CFG_TIMEOUT = 3'd1;
  localparam logic [2:0] CFG_LIMIT   = 3'd2;
  localparam logic [2:0] CFG_SEQ_A   = 3'd3;
  localparam int         NumCfgSeq   = 3;

  // Chord type codes.
  localparam logic [3:0] CT_UNKNOWN = 4'd0;
  localparam logic [3:0] CT_MAJ     = 4'd1;
  localparam logic [3:0] CT_MAJ7    = 4'd2;
  localparam logic [3:0] CT_DOM7    = 4'd3;
  localparam logic [3:0] CT_MIN     = 4'd4;
  localparam logic [3:0] CT_MIN7    = 4'd5;
  localparam logic [3:0] CT_DIM     = 4'd6;
  localparam logic [3:0] CT_AUG     = 4'd7;
  localparam logic [3:0] CT_SUS4    = 4'd8;
  localparam logic [3:0] CT_SUS2    = 4'd9;

  localparam logic [3:0] LAST_ROOT = 4'd11;
  localparam int         MinChordNotes = 3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROOT,
    ST_SEQ,
    ST_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic root_step;
    logic push;
    logic seq_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic end_beat;
    logic analyze;
    logic match;
    logic dup_chord;
    logic root_last;
    logic seq_last;
    logic out_free;
  } status_t;

  // Pitch class of a MIDI note: quotient by 12 through a reciprocal multiply,
  // exact for all 7-bit notes.
  function automatic logic [3:0] pitch_class(input logic [6:0] note);
    logic [14:0] prod;
    logic [3:0]  quo;
    logic [6:0]  rem;
    prod = 15'(note) * 15'd171;
    quo  = prod[14:11];
    rem  = note - (7'(quo) * 7'd12);
    return rem[3:0];
  endfunction

  // Match an interval mask (root at bit 0) against the chord templates.
  function automatic logic [3:0] match_templates(input logic [11:0] iv);
    logic [3:0] t;
    t = CT_UNKNOWN;
    if ((iv & 12'h091) == 12'h091) begin
      if (iv[11]) t = CT_MAJ7;
      else if (iv[10]) t = CT_DOM7;
      else t = CT_MAJ;
    end else if ((iv & 12'h089) == 12'h089) begin
      t = iv[10] ? CT_MIN7 : CT_MIN;
    end else if ((iv & 12'h049) == 12'h049) begin
      t = CT_DIM;
    end else if ((iv & 12'h111) == 12'h111) begin
      t = CT_AUG;
    end else if ((iv & 12'h0A1) == 12'h0A1) begin
      t = CT_SUS4;
    end else if ((iv & 12'h085) == 12'h085) begin
      t = CT_SUS2;
    end
    return t;
  endfunction

endpackage

// ===== rtl/midi_chord_sequence_detector.sv =====
// Top level of the MIDI chord sequence detector.
// Holds the configuration registers and joins mcsd_ctrl and mcsd_dp;
// depends on mcsd_pkg.
`timescale 1ns / 1ps

// Takes note-on, note-off and buffer-end beats. Note beats update the held-note
// map and give no result. A buffer-end beat gives one result beat (none while
// enable is 0): it goes straight to the result when no chord analysis is due,
// and otherwise first runs the root scan (one candidate root per cycle) and,
// after a new chord, the sequence scan (one slot per cycle). Input is taken
// only between buffer-end analyses; a finished result waits in an output
// register, so input keeps flowing while it is not yet taken. No clearing
// pass is needed after reset.
module midi_chord_sequence_detector
  import mcsd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8,
  parameter int NUM_SEQUENCES = 3,
  parameter int MAX_SEQ_LEN   = 4
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [2:0]                              cfg_index_i,
  input  logic [((3 + 8 * MAX_SEQ_LEN) > 32 ? (3 + 8 * MAX_SEQ_LEN) : 32)-1:0]
                                                  cfg_data_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [1:0]                              kind_i,
  input  logic [6:0]                              note_i,
  input  logic [31:0]                             time_ms_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    chord_present_o,
  output logic [3:0]                              chord_root_o,
  output logic [3:0]                              chord_type_o,
  output logic                                    new_chord_o,
  output logic                                    history_cleared_o,
  output logic [NUM_SEQUENCES-1:0]                unlocked_mask_o,
  output logic [NUM_SEQUENCES-1:0]                newly_unlocked_o
);

  localparam int SEQ_BITS = 3 + 8 * MAX_SEQ_LEN;

  logic                                   enable_q;
  logic [31:0]                            timeout_q;
  logic [3:0]                             limit_q;
  logic [NUM_SEQUENCES-1:0][SEQ_BITS-1:0] seq_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b1;
      timeout_q <= 32'd2000;
      limit_q   <= 4'd8;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ENABLE:  enable_q  <= cfg_data_i[0];
        CFG_TIMEOUT: timeout_q <= cfg_data_i[31:0];
        CFG_LIMIT:   limit_q   <= cfg_data_i[3:0];
        default:     ;
      endcase
    end
  end

  // Sequence slots; slots past the register list stay unused.
  for (genvar s = 0; s < NUM_SEQUENCES; s++) begin : g_seq
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        seq_q[s] <= '0;
      end else if (cfg_we_i && (s < NumCfgSeq) &&
                   (cfg_index_i == CFG_SEQ_A + 3'(s))) begin
        seq_q[s] <= cfg_data_i[SEQ_BITS-1:0];
      end
    end
  end

  cmd_t    cmd;
  status_t st;

  mcsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  mcsd_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .NUM_SEQUENCES (NUM_SEQUENCES),
    .MAX_SEQ_LEN   (MAX_SEQ_LEN),
    .SEQ_BITS      (SEQ_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .st_o              (st),
    .cfg_enable_i      (enable_q),
    .cfg_timeout_i     (timeout_q),
    .cfg_limit_i       (limit_q),
    .cfg_seq_i         (seq_q),
    .kind_i            (kind_i),
    .note_i            (note_i),
    .time_ms_i         (time_ms_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .chord_present_o   (chord_present_o),
    .chord_root_o      (chord_root_o),
    .chord_type_o      (chord_type_o),
    .new_chord_o       (new_chord_o),
    .history_cleared_o (history_cleared_o),
    .unlocked_mask_o   (unlocked_mask_o),
    .newly_unlocked_o  (newly_unlocked_o)
  );

`ifndef NO_ASSERTIONS
  // A newly unlocked slot is always part of the unlocked mask.
  a_newly_in_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((newly_unlocked_o & ~unlocked_mask_o) == '0))
    else $error("newly unlocked slot missing from unlocked mask");

  // Unlocks happen only on a beat that pushed a chord.
  a_unlock_needs_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (newly_unlocked_o != '0)) |-> new_chord_o)
    else $error("unlock reported without a new chord");

  // A pushed chord is the current chord.
  a_push_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && new_chord_o) |-> (chord_present_o && (chord_type_o != CT_UNKNOWN)))
    else $error("new chord reported while no chord present");

  // With no chord present, root and type read as zero.
  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !chord_present_o) |-> ((chord_root_o == 4'd0) &&
                                           (chord_type_o == CT_UNKNOWN)))
    else $error("absent chord with nonzero root or type");
`endif

endmodule

// ===== rtl/mcsd_ctrl.sv =====
// Controller for the MIDI chord sequence detector.
// Sequences the root scan, history push, sequence scan and result hand-off;
// depends on mcsd_pkg for the state type and command/status structs.
`timescale 1ns / 1ps

module mcsd_ctrl
  import mcsd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && st_i.end_beat) begin
          state_d = st_i.analyze ? ST_ROOT : ST_DONE;
        end
      end
      ST_ROOT: begin
        if (st_i.match) begin
          state_d = st_i.dup_chord ? ST_DONE : ST_SEQ;
        end else if (st_i.root_last) begin
          state_d = ST_DONE;
        end
      end
      ST_SEQ: begin
        if (st_i.seq_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (st_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_ROOT: begin
        cmd_o.root_step = !st_i.match;
        cmd_o.push      = st_i.match && !st_i.dup_chord;
      end
      ST_SEQ: begin
        cmd_o.seq_step = 1'b1;
      end
      ST_DONE: begin
        cmd_o.load_out = st_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// ===== rtl/mcsd_dp.sv =====
// Datapath for the MIDI chord sequence detector.
// Holds the note map, pitch-class counts, chord state, history shift line,
// unlock flags and the output register; depends on mcsd_pkg.
`timescale 1ns / 1ps

module mcsd_dp
  import mcsd_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8,
  parameter int NUM_SEQUENCES = 3,
  parameter int MAX_SEQ_LEN   = 4,
  parameter int SEQ_BITS      = 3 + 8 * MAX_SEQ_LEN
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cmd_t                                   cmd_i,
  output status_t                                st_o,
  input  logic                                   cfg_enable_i,
  input  logic [31:0]                            cfg_timeout_i,
  input  logic [3:0]                             cfg_limit_i,
  input  logic [NUM_SEQUENCES-1:0][SEQ_BITS-1:0] cfg_seq_i,
  input  logic [1:0]                             kind_i,
  input  logic [6:0]                             note_i,
  input  logic [31:0]                            time_ms_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   chord_present_o,
  output logic [3:0]                             chord_root_o,
  output logic [3:0]                             chord_type_o,
  output logic                                   new_chord_o,
  output logic                                   history_cleared_o,
  output logic [NUM_SEQUENCES-1:0]               unlocked_mask_o,
  output logic [NUM_SEQUENCES-1:0]               newly_unlocked_o
);

  localparam int HIDX_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int IW     = HIDX_W + 3;
  localparam int SIDX_W = (NUM_SEQUENCES > 1) ? $clog2(NUM_SEQUENCES) : 1;

  // Control state.
  logic [127:0]             held_q;
  logic [7:0]               held_cnt_q;
  logic [11:0][3:0]         pc_cnt_q;
  logic                     changed_q;
  logic                     cur_valid_q;
  logic [3:0]               cur_root_q, cur_type_q;
  logic                     last_valid_q;
  logic [7:0]               last_chord_q;
  logic [31:0]              last_time_q;
  logic [CNT_W-1:0]         hist_cnt_q;
  logic [NUM_SEQUENCES-1:0] unlocked_q;
  logic [3:0]               root_q;
  logic [SIDX_W-1:0]        seq_q;
  logic                     pushed_q, cleared_q;
  logic [NUM_SEQUENCES-1:0] newly_q;
  logic [31:0]              time_q;
  logic                     out_valid_q;

  // Payload state.
  logic [HISTORY_DEPTH-1:0][7:0] hist_q;
  logic                          o_present_q, o_new_q, o_cleared_q;
  logic [3:0]                    o_root_q, o_type_q;
  logic [NUM_SEQUENCES-1:0]      o_mask_q, o_newly_q;

  // Event decode and note lookup.
  logic       ev_on, ev_off, ev_end;
  logic [3:0] note_pc;
  logic       note_held;
  assign ev_on     = cmd_i.accept && cfg_enable_i && (kind_i == KIND_NOTE_ON);
  assign ev_off    = cmd_i.accept && cfg_enable_i && (kind_i == KIND_NOTE_OFF);
  assign ev_end    = cfg_enable_i && (kind_i == KIND_BUF_END);
  assign note_pc   = pitch_class(note_i);
  assign note_held = held_q[note_i];

  // Pitch-class set and chord gate.
  logic [11:0] pcs;
  logic        enough;
  always_comb begin
    for (int p = 0; p < 12; p++) pcs[p] = (pc_cnt_q[p] != 4'd0);
  end
  assign enough = (held_cnt_q >= 8'(MinChordNotes));

  // Timeout check against the last pushed chord.
  logic [31:0] elapsed;
  logic        timed_out;
  assign elapsed   = time_ms_i - last_time_q;
  assign timed_out = (elapsed > cfg_timeout_i) && (hist_cnt_q != '0);

  // Root scan: rotate the set so the candidate root sits at bit 0.
  logic [23:0] pcs2;
  logic [23:0] rot;
  logic [11:0] iv;
  logic [3:0]  cand_type;
  logic [7:0]  cand_chord;
  assign pcs2       = {pcs, pcs};
  assign rot        = pcs2 >> root_q;
  assign iv         = rot[11:0];
  assign cand_type  = match_templates(iv);
  assign cand_chord = {root_q, cand_type};

  // History limit, clamped to 1..HISTORY_DEPTH.
  logic [CNT_W-1:0] lim;
  logic [CNT_W-1:0] cnt_inc;
  always_comb begin
    if (cfg_limit_i == 4'd0) lim = CNT_W'(1);
    else if (32'(cfg_limit_i) > HISTORY_DEPTH) lim = CNT_W'(HISTORY_DEPTH);
    else lim = CNT_W'(cfg_limit_i);
    cnt_inc = (hist_cnt_q >= lim) ? lim : hist_cnt_q + CNT_W'(1);
  end

  // Sequence match for the slot under scan.
  logic [SEQ_BITS-1:0] sreg;
  logic [2:0]          slen;
  logic                seq_hit;
  always_comb begin
    logic [IW-1:0] li;
    logic [IW-1:0] idx;
    sreg    = cfg_seq_i[seq_q];
    slen    = sreg[2:0];
    li      = IW'(slen);
    seq_hit = (slen != 3'd0) && (32'(slen) <= MAX_SEQ_LEN) &&
              (IW'(hist_cnt_q) >= li);
    for (int i = 0; i < MAX_SEQ_LEN; i++) begin
      idx = li - IW'(i) - IW'(1);
      if (i < 32'(slen)) begin
        if (!((idx < IW'(HISTORY_DEPTH)) &&
              (hist_q[idx[HIDX_W-1:0]] == sreg[3 + 8 * i +: 8]))) begin
          seq_hit = 1'b0;
        end
      end
    end
  end

  // Status to the controller.
  assign st_o.end_beat  = ev_end;
  assign st_o.analyze   = changed_q && enough;
  assign st_o.match     = pcs[root_q] && (cand_type != CT_UNKNOWN);
  assign st_o.dup_chord = last_valid_q && (last_chord_q == cand_chord);
  assign st_o.root_last = (root_q == LAST_ROOT);
  assign st_o.seq_last  = (32'(seq_q) == NUM_SEQUENCES - 1);
  assign st_o.out_free  = !out_valid_q || out_ready_i;

  // Note map and counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      held_cnt_q <= '0;
      pc_cnt_q   <= '0;
      changed_q  <= 1'b0;
    end else begin
      if (ev_on || ev_off) changed_q <= 1'b1;
      else if (cmd_i.accept && ev_end) changed_q <= 1'b0;
      if (ev_on && !note_held) begin
        held_q[note_i]    <= 1'b1;
        held_cnt_q        <= held_cnt_q + 8'd1;
        pc_cnt_q[note_pc] <= pc_cnt_q[note_pc] + 4'd1;
      end else if (ev_off && note_held) begin
        held_q[note_i]    <= 1'b0;
        held_cnt_q        <= held_cnt_q - 8'd1;
        pc_cnt_q[note_pc] <= pc_cnt_q[note_pc] - 4'd1;
      end
    end
  end

  // Chord state, history count, unlock flags and scan counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q  <= 1'b0;
      cur_root_q   <= '0;
      cur_type_q   <= CT_UNKNOWN;
      last_valid_q <= 1'b0;
      last_chord_q <= '0;
      last_time_q  <= '0;
      hist_cnt_q   <= '0;
      unlocked_q   <= '0;
      root_q       <= '0;
      seq_q        <= '0;
      pushed_q     <= 1'b0;
      cleared_q    <= 1'b0;
      newly_q      <= '0;
      time_q       <= '0;
    end else begin
      if (cmd_i.accept && ev_end) begin
        root_q    <= '0;
        seq_q     <= '0;
        pushed_q  <= 1'b0;
        newly_q   <= '0;
        cleared_q <= timed_out;
        time_q    <= time_ms_i;
        if (timed_out) hist_cnt_q <= '0;
        if (!enough) begin
          cur_valid_q <= 1'b0;
          cur_root_q  <= '0;
          cur_type_q  <= CT_UNKNOWN;
        end
      end
      if (cmd_i.root_step) root_q <= root_q + 4'd1;
      if (cmd_i.push) begin
        cur_valid_q  <= 1'b1;
        cur_root_q   <= root_q;
        cur_type_q   <= cand_type;
        last_valid_q <= 1'b1;
        last_chord_q <= cand_chord;
        last_time_q  <= time_q;
        hist_cnt_q   <= cnt_inc;
        pushed_q     <= 1'b1;
      end
      if (cmd_i.seq_step) begin
        seq_q <= seq_q + SIDX_W'(1);
        if (!unlocked_q[seq_q] && seq_hit) begin
          unlocked_q[seq_q] <= 1'b1;
          newly_q[seq_q]    <= 1'b1;
        end
      end
    end
  end

  // History shift line, newest at entry 0.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      hist_q <= {hist_q[HISTORY_DEPTH-2:0], cand_chord};
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      o_present_q <= cur_valid_q;
      o_root_q    <= cur_root_q;
      o_type_q    <= cur_type_q;
      o_new_q     <= pushed_q;
      o_cleared_q <= cleared_q;
      o_mask_q    <= unlocked_q;
      o_newly_q   <= newly_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign chord_present_o   = o_present_q;
  assign chord_root_o      = o_root_q;
  assign chord_type_o      = o_type_q;
  assign new_chord_o       = o_new_q;
  assign history_cleared_o = o_cleared_q;
  assign unlocked_mask_o   = o_mask_q;
  assign newly_unlocked_o  = o_newly_q;

endmodule

// ===== sim/mcsd_chord_checker.sv =====
// Checker for the MIDI chord sequence detector testbench.
// Watches the config port and both channels, predicts results and compares them;
// depends on mcsd_pkg.
`timescale 1ns / 1ps

module mcsd_chord_checker
  import mcsd_pkg::*;
#(
  parameter int CfgW = 35
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_index_i,
  input  logic [CfgW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic [1:0]      kind_i,
  input  logic [6:0]      note_i,
  input  logic [31:0]     time_ms_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  logic            chord_present_i,
  input  logic [3:0]      chord_root_i,
  input  logic [3:0]      chord_type_i,
  input  logic            new_chord_i,
  input  logic            history_cleared_i,
  input  logic [2:0]      unlocked_mask_i,
  input  logic [2:0]      newly_unlocked_i,
  output int              pending_o,
  output int              checked_o,
  output int              pushes_o,
  output int              errors_o
);

  typedef struct packed {
    logic       present;
    logic [3:0] root;
    logic [3:0] ctype;
    logic       new_chord;
    logic       cleared;
    logic [2:0] mask;
    logic [2:0] newly;
  } chord_result_t;

  // Copy of the configuration registers.
  logic            en_q;
  logic [31:0]     timeout_q;
  logic [3:0]      limit_q;
  logic [CfgW-1:0] seq_q [3];

  // Copy of the detector state.
  logic [127:0] held_q;
  logic         changed_q;
  logic         cur_valid_q;
  logic [3:0]   cur_root_q, cur_type_q;
  logic         last_valid_q;
  logic [3:0]   last_root_q, last_type_q;
  logic [31:0]  last_time_q;
  logic [7:0]   history_q [8];
  int           hist_count_q;
  logic [2:0]   unlocked_q;

  chord_result_t expected_results[$];

  assign pending_o = expected_results.size();

  task automatic report(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  // Finds the lowest present root that fits a template; type 0 when none does.
  task automatic name_chord(input logic [11:0] pcs, output logic [3:0] root,
                            output logic [3:0] ctype);
    logic [23:0] twice;
    logic [11:0] iv;
    root  = 4'd0;
    ctype = CT_UNKNOWN;
    twice = {pcs, pcs};
    for (int r = 0; r < 12; r++) begin
      if (pcs[r] && ctype == CT_UNKNOWN) begin
        iv = twice[r +: 12];
        root = 4'(r);
        if (iv[4] && iv[7]) ctype = iv[11] ? CT_MAJ7 : (iv[10] ? CT_DOM7 : CT_MAJ);
        else if (iv[3] && iv[7]) ctype = iv[10] ? CT_MIN7 : CT_MIN;
        else if (iv[3] && iv[6]) ctype = CT_DIM;
        else if (iv[4] && iv[8]) ctype = CT_AUG;
        else if (iv[5] && iv[7]) ctype = CT_SUS4;
        else if (iv[2] && iv[7]) ctype = CT_SUS2;
      end
    end
    if (ctype == CT_UNKNOWN) root = 4'd0;
  endtask

  // A slot matches when its chords, oldest first, equal the newest history.
  function automatic logic slot_matches(input logic [CfgW-1:0] word);
    int len;
    len = int'(word[2:0]);
    if (len == 0 || len > 4 || hist_count_q < len) return 1'b0;
    for (int i = 0; i < len; i++)
      if (history_q[len-1-i] != word[3+8*i +: 8]) return 1'b0;
    return 1'b1;
  endfunction

  // Updates the state for one input beat and queues its result, if any.
  task automatic absorb_event(input logic [1:0] kind, input logic [6:0] note,
                              input logic [31:0] now);
    chord_result_t res;
    int            held;
    logic [11:0]   pcs;
    logic [3:0]    root, ctype;
    int            lim;
    if (!en_q) return;
    if (kind == KIND_NOTE_ON || kind == KIND_NOTE_OFF) begin
      held_q[note] = (kind == KIND_NOTE_ON);
      changed_q = 1'b1;
      return;
    end
    if (kind != KIND_BUF_END) return;
    res = '0;
    if ((now - last_time_q) > timeout_q && hist_count_q > 0) begin
      hist_count_q = 0;
      res.cleared = 1'b1;
    end
    held = 0;
    pcs = '0;
    for (int n = 0; n < 128; n++)
      if (held_q[n]) begin
        held++;
        pcs[n % 12] = 1'b1;
      end
    if (changed_q && held >= 3) begin
      name_chord(pcs, root, ctype);
      if (ctype != CT_UNKNOWN &&
          !(last_valid_q && last_root_q == root && last_type_q == ctype)) begin
        cur_valid_q = 1'b1;
        cur_root_q = root;
        cur_type_q = ctype;
        lim = (limit_q == 0) ? 1 : ((limit_q > 8) ? 8 : int'(limit_q));
        for (int i = 7; i > 0; i--) history_q[i] = history_q[i-1];
        history_q[0] = {root, ctype};
        hist_count_q = (hist_count_q + 1 > lim) ? lim : hist_count_q + 1;
        last_valid_q = 1'b1;
        last_root_q = root;
        last_type_q = ctype;
        last_time_q = now;
        res.new_chord = 1'b1;
        for (int s = 0; s < 3; s++)
          if (!unlocked_q[s] && slot_matches(seq_q[s])) begin
            unlocked_q[s] = 1'b1;
            res.newly[s] = 1'b1;
          end
      end
    end else if (held < 3) begin
      cur_valid_q = 1'b0;
      cur_root_q = '0;
      cur_type_q = '0;
    end
    changed_q = 1'b0;
    res.present = cur_valid_q;
    res.root = cur_valid_q ? cur_root_q : 4'd0;
    res.ctype = cur_valid_q ? cur_type_q : 4'd0;
    res.mask = unlocked_q;
    expected_results = {expected_results, res};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    chord_result_t want;
    if (!rst_ni) begin
      en_q = 1'b1;
      timeout_q = 32'd2000;
      limit_q = 4'd8;
      for (int s = 0; s < 3; s++) seq_q[s] = '0;
      held_q = '0;
      changed_q = 1'b0;
      cur_valid_q = 1'b0;
      cur_root_q = '0;
      cur_type_q = '0;
      last_valid_q = 1'b0;
      last_root_q = '0;
      last_type_q = '0;
      last_time_q = '0;
      for (int i = 0; i < 8; i++) history_q[i] = '0;
      hist_count_q = 0;
      unlocked_q = '0;
      expected_results.delete();
      checked_o = 0;
      pushes_o = 0;
      errors_o = 0;
    end else begin
      // Result beat first: it can never belong to an input beat of this edge.
      if (out_valid_i && out_ready_i) begin
        checked_o++;
        if (expected_results.size() == 0) begin
          report("unexpected result beat", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (new_chord_i) pushes_o++;
          if (chord_present_i !== want.present)
            report("chord_present", chord_present_i, want.present);
          if (chord_root_i !== want.root) report("chord_root", chord_root_i, want.root);
          if (chord_type_i !== want.ctype) report("chord_type", chord_type_i, want.ctype);
          if (new_chord_i !== want.new_chord)
            report("new_chord", new_chord_i, want.new_chord);
          if (history_cleared_i !== want.cleared)
            report("history_cleared", history_cleared_i, want.cleared);
          if (unlocked_mask_i !== want.mask)
            report("unlocked_mask", unlocked_mask_i, want.mask);
          if (newly_unlocked_i !== want.newly)
            report("newly_unlocked", newly_unlocked_i, want.newly);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_ENABLE:  en_q = cfg_data_i[0];
          CFG_TIMEOUT: timeout_q = cfg_data_i[31:0];
          CFG_LIMIT:   limit_q = cfg_data_i[3:0];
          default: begin
            if (cfg_index_i >= CFG_SEQ_A && cfg_index_i < CFG_SEQ_A + NumCfgSeq)
              seq_q[cfg_index_i - CFG_SEQ_A] = cfg_data_i;
          end
        endcase
      end
      if (in_valid_i && in_ready_i) absorb_event(kind_i, note_i, time_ms_i);
    end
  end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the MIDI chord sequence detector.
// Drives events and config writes, paces the result side and gives the verdict;
// depends on mcsd_pkg, midi_chord_sequence_detector and mcsd_chord_checker.
`timescale 1ns / 1ps

module tb;
  import mcsd_pkg::*;

  localparam int CfgW = 35;
  localparam int CycleLimit = 400000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [2:0]      cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [1:0]      kind_i = '0;
  logic [6:0]      note_i = '0;
  logic [31:0]     time_ms_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic            chord_present_o, new_chord_o, history_cleared_o;
  logic [3:0]      chord_root_o, chord_type_o;
  logic [2:0]      unlocked_mask_o, newly_unlocked_o;
  int              pending, checked, pushes, errors;

  logic         calm = 1'b0;       // no idling on either side while set
  logic         hold_req = 1'b0;   // asks the receiver for a long hold-off
  logic [127:0] keys_down = '0;
  logic [31:0]  clock_ms = 32'd100;
  int           beats_sent = 0;
  int           cycles = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  midi_chord_sequence_detector u_top (.*);

  mcsd_chord_checker #(.CfgW(CfgW)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .note_i, .time_ms_i,
    .out_valid_i(out_valid_o), .out_ready_i, .chord_present_i(chord_present_o),
    .chord_root_i(chord_root_o), .chord_type_i(chord_type_o),
    .new_chord_i(new_chord_o), .history_cleared_i(history_cleared_o),
    .unlocked_mask_i(unlocked_mask_o), .newly_unlocked_i(newly_unlocked_o),
    .pending_o(pending), .checked_o(checked), .pushes_o(pushes), .errors_o(errors)
  );

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req <= 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // Offers one beat and returns at the edge where it is taken.
  task automatic put(input logic [1:0] kind, input logic [6:0] note,
                     input logic [31:0] t);
    if (!calm && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    note_i <= note;
    time_ms_i <= t;
    do @(posedge clk_i); while (!in_ready_o);
    if (kind == KIND_NOTE_ON) keys_down[note] = 1'b1;
    if (kind == KIND_NOTE_OFF) keys_down[note] = 1'b0;
    beats_sent++;
  endtask

  task automatic buffer_end(input int step_ms);
    clock_ms += 32'(step_ms);
    put(KIND_BUF_END, 7'($urandom_range(0, 127)), clock_ms);
  endtask

  // Releases every key and plays one chord shape on a random octave.
  task automatic play(input logic [3:0] root, input logic [3:0] ctype);
    int tones[$];
    int base;
    for (int n = 0; n < 128; n++)
      if (keys_down[n]) put(KIND_NOTE_OFF, 7'(n), $urandom);
    case (ctype)
      CT_MAJ:  tones = '{0, 4, 7};
      CT_MAJ7: tones = '{0, 4, 7, 11};
      CT_DOM7: tones = '{0, 4, 7, 10};
      CT_MIN:  tones = '{0, 3, 7};
      CT_MIN7: tones = '{0, 3, 7, 10};
      CT_DIM:  tones = '{0, 3, 6};
      CT_AUG:  tones = '{0, 4, 8};
      CT_SUS4: tones = '{0, 5, 7};
      default: tones = '{0, 2, 7};
    endcase
    base = 12 * $urandom_range(0, 9) + int'(root);
    foreach (tones[i]) put(KIND_NOTE_ON, 7'((base + tones[i]) % 128), $urandom);
    buffer_end($urandom_range(1, 400));
  endtask

  // Waits until the block is idle, then writes one register.
  task automatic write_reg(input logic [2:0] idx, input logic [CfgW-1:0] data);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [CfgW-1:0] seq_word(input logic [2:0] len,
      input logic [7:0] c0, c1, c2, c3);
    return {c3, c2, c1, c0, len};
  endfunction

  function automatic logic [7:0] rand_chord();
    return {4'($urandom_range(0, 11)), 4'($urandom_range(1, 3))};
  endfunction

  initial begin
    logic [7:0] prog [4];
    int         mode;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: sequences of C, F, G major; out-of-range slot settings.
    write_reg(CFG_SEQ_A, seq_word(3'd3, {4'd0, CT_MAJ}, {4'd5, CT_MAJ},
                                  {4'd7, CT_MAJ}, 8'h00));
    write_reg(CFG_SEQ_A + 3'd1, seq_word(3'd5, 8'h01, 8'h01, 8'h01, 8'h01));
    write_reg(CFG_SEQ_A + 3'd2, seq_word(3'd1, 8'hC1, 8'h00, 8'h00, 8'h00));
    // Extreme notes with fewer than three keys held.
    put(KIND_NOTE_ON, 7'd0, 32'hFFFF_FFFF);
    put(KIND_NOTE_ON, 7'd127, 32'h0);
    buffer_end(5);
    put(KIND_NOTE_OFF, 7'd127, 32'h0);
    put(2'd3, 7'd55, 32'hA5A5_5A5A);
    play(4'd0, CT_MAJ);
    buffer_end(3);           // no note change since the last analysis
    play(4'd5, CT_MAJ);
    play(4'd7, CT_MAJ);
    for (int t = CT_MAJ7; t <= CT_SUS2; t++) play(4'(t), 4'(t));
    // Timeout clears history; then the clock wraps around.
    play(4'd11, CT_MIN);
    buffer_end(2500);
    clock_ms = 32'hFFFF_FF00;
    play(4'd2, CT_DOM7);
    play(4'd9, CT_MAJ);

    // Extreme settings: detection off, zero and maximum timeout, history limits.
    write_reg(CFG_ENABLE, '0);
    play(4'd4, CT_MIN);
    write_reg(CFG_ENABLE, 1);
    write_reg(CFG_TIMEOUT, '0);
    write_reg(CFG_LIMIT, '0);
    play(4'd1, CT_MAJ);
    buffer_end(1);
    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(CFG_LIMIT, 4'd15);

    // Random: progressions that the slots wait for, with noise between them.
    while (beats_sent < 540) begin
      if (beats_sent > 150 && beats_sent < 260) calm = 1'b1;
      else calm = 1'b0;
      if ($urandom_range(0, 5) == 0) begin
        for (int i = 0; i < 4; i++) prog[i] = rand_chord();
        write_reg(CFG_SEQ_A + 3'($urandom_range(0, 2)),
                  seq_word(3'($urandom_range(1, 4)), prog[0], prog[1], prog[2], prog[3]));
        write_reg(CFG_LIMIT, 4'($urandom_range(0, 15)));
        write_reg(CFG_TIMEOUT, ($urandom_range(0, 3) == 0) ? $urandom
                                                           : 32'($urandom_range(200, 3000)));
        if ($urandom_range(0, 3) == 0) begin
          write_reg(CFG_ENABLE, '0);
          put(KIND_NOTE_ON, 7'($urandom_range(0, 127)), $urandom);
          buffer_end(10);
          write_reg(CFG_ENABLE, 1);
        end
        for (int i = 0; i < 4; i++) play(prog[i][7:4], prog[i][3:0]);
      end
      if (beats_sent > 300 && beats_sent < 330) hold_req = 1'b1;
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        play(4'($urandom_range(0, 11)), 4'($urandom_range(1, 9)));
      end else if (mode < 9) begin
        put(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)), $urandom);
        if ($urandom_range(0, 1)) buffer_end($urandom_range(0, 3000));
      end else begin
        put(KIND_BUF_END, 7'($urandom_range(0, 127)), $urandom);
      end
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d event beats; checked %0d result beats, %0d of them new chords.",
             beats_sent, checked, pushes);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/mcsd_pkg.sv
rtl/mcsd_ctrl.sv
rtl/mcsd_dp.sv
rtl/midi_chord_sequence_detector.sv
sim/mcsd_chord_checker.sv
sim/tb.sv
